/* hw/rtl/aprep_pkg.sv */
`default_nettype none

package aprep_pkg;

	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 32;

	// Widths; the index, count and page widths follow from the frame count and page width
	localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W   = $clog2(FRAMES + 1);
	localparam int PAGE_W  = (PAGE_BITS < 32) ? PAGE_BITS : 32;
	localparam int CFG_W   = 5;
	localparam int FRAME_W = 4;
	localparam int TOTAL_W = 32;
	localparam int AGE_W   = 8;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_AGE,
		ST_DONE
	} state_t;

	// One frame entry as read from the frame table
	typedef struct packed {
		logic              valid;
		logic [PAGE_W-1:0] page;
		logic [AGE_W-1:0]  age;
	} frame_rd_t;

	// One write into the frame table
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  idx;
		logic              load;
		logic [PAGE_W-1:0] page;
		logic [AGE_W-1:0]  age;
	} frame_wr_t;

	// Result handed from the sequencer to the output register
	typedef struct packed {
		logic               hit;
		logic [FRAME_W-1:0] frame;
		logic               evicted;
		logic [31:0]        evicted_page;
		logic [TOTAL_W-1:0] hit_total;
		logic [TOTAL_W-1:0] miss_total;
	} result_t;

	// Clamp the configured frame count to 1..FRAMES
	function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] c);
		logic [7:0] v;
		v = {3'b000, c};
		if (v == 8'd0)
			v = 8'd1;
		if (v > 8'(FRAMES))
			v = 8'(FRAMES);
		return v[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/aprep_frames.sv */
`default_nettype none

module aprep_frames
	import aprep_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [IDX_W-1:0] rd_idx,
	output frame_rd_t       rd,
	input  wire frame_wr_t  wr
);

	logic              valid_q [FRAMES];
	logic [PAGE_W-1:0] page_q  [FRAMES];
	logic [AGE_W-1:0]  age_q   [FRAMES];

	// Clear valid bits on reset, set them on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++)
				valid_q[i] <= 1'b0;
		end else if (wr.we && wr.load) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	// Write page and age payload
	always_ff @(posedge clk) begin
		if (wr.we) begin
			if (wr.load)
				page_q[wr.idx] <= wr.page;
			age_q[wr.idx] <= wr.age;
		end
	end

	// Read one frame at the scan index
	always_comb begin
		rd.valid = valid_q[rd_idx];
		rd.page  = page_q[rd_idx];
		rd.age   = age_q[rd_idx];
	end

endmodule

`default_nettype wire

/* hw/rtl/aprep_seq.sv */
`default_nettype none

module aprep_seq
	import aprep_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CFG_W-1:0]  frames_cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [31:0]       in_page,
	output logic [IDX_W-1:0]       rd_idx,
	input  wire frame_rd_t         rd,
	output frame_wr_t              wr,
	output logic                   res_valid,
	input  wire logic              res_free,
	output result_t                res
);

	state_t state_q, state_d;

	logic [IDX_W-1:0]   idx_q, last_q, slot_q, empty_idx_q, best_idx_q;
	logic [PAGE_W-1:0]  pg_q, best_page_q, old_page_q;
	logic [AGE_W-1:0]   best_age_q;
	logic               hit_q, empty_found_q, evict_q;
	logic [TOTAL_W-1:0] hit_cnt_q, miss_cnt_q;

	logic               eq, lt, take_best, at_last, is_slot;
	logic               emp_now;
	logic [IDX_W-1:0]   emp_idx_now, best_idx_now;
	logic [PAGE_W-1:0]  best_page_now;
	logic [CNT_W-1:0]   n_act;
	logic [CNT_W-1:0]   n_last;
	logic [IDX_W+FRAME_W-1:0] slot_ext;

	// Shared compare unit: page match and age ordering on the scanned frame
	assign eq        = rd.valid && (rd.page == pg_q);
	assign lt        = (idx_q == '0) || (rd.age < best_age_q);
	assign take_best = rd.valid && lt;
	assign at_last   = (idx_q == last_q);
	assign is_slot   = (idx_q == slot_q);

	assign emp_now       = empty_found_q || !rd.valid;
	assign emp_idx_now   = empty_found_q ? empty_idx_q : idx_q;
	assign best_idx_now  = take_best ? idx_q : best_idx_q;
	assign best_page_now = take_best ? rd.page : best_page_q;

	assign n_act  = active_count(frames_cfg);
	assign n_last = n_act - CNT_W'(1);

	assign rd_idx   = idx_q;
	assign in_ready = (state_q == ST_IDLE);

	assign slot_ext = {{FRAME_W{1'b0}}, slot_q};

	always_comb begin
		res.hit          = hit_q;
		res.frame        = slot_ext[FRAME_W-1:0];
		res.evicted      = evict_q;
		res.evicted_page = 32'(old_page_q);
		res.hit_total    = hit_cnt_q;
		res.miss_total   = miss_cnt_q;
	end

	// Hold state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state, table writes and result strobe
	always_comb begin
		state_d   = state_q;
		res_valid = 1'b0;
		wr.we     = 1'b0;
		wr.idx    = idx_q;
		wr.load   = is_slot && !hit_q;
		wr.page   = pg_q;
		wr.age    = wr.load ? {1'b1, {(AGE_W-1){1'b0}}} : {is_slot, rd.age[AGE_W-1:1]};
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (eq || at_last)
					state_d = ST_AGE;
			end
			ST_AGE: begin
				wr.we = is_slot || rd.valid;
				if (at_last)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Count hits and misses, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			if (eq) begin
				if (hit_cnt_q != '1)
					hit_cnt_q <= hit_cnt_q + TOTAL_W'(1);
			end else if (at_last) begin
				if (miss_cnt_q != '1)
					miss_cnt_q <= miss_cnt_q + TOTAL_W'(1);
			end
		end
	end

	// Scan index and per-item working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: idx_q <= '0;
				ST_SCAN: idx_q <= (eq || at_last) ? '0 : idx_q + IDX_W'(1);
				ST_AGE:  idx_q <= at_last ? '0 : idx_q + IDX_W'(1);
				default: idx_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					pg_q          <= in_page[PAGE_W-1:0];
					last_q        <= n_last[IDX_W-1:0];
					empty_found_q <= 1'b0;
					hit_q         <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (eq) begin
					hit_q      <= 1'b1;
					slot_q     <= idx_q;
					evict_q    <= 1'b0;
					old_page_q <= '0;
				end else begin
					if (!rd.valid && !empty_found_q) begin
						empty_found_q <= 1'b1;
						empty_idx_q   <= idx_q;
					end
					if (take_best) begin
						best_age_q  <= rd.age;
						best_idx_q  <= idx_q;
						best_page_q <= rd.page;
					end
					// Pick the empty frame, else the oldest one
					if (at_last) begin
						slot_q     <= emp_now ? emp_idx_now : best_idx_now;
						evict_q    <= !emp_now;
						old_page_q <= emp_now ? '0 : best_page_now;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/aging_page_replacement.sv */
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  page_number
// m_axis    out        m_axis_tvalid / m_axis_tready  hit, frame, evicted, evicted_page,
//                                                     hit_total, miss_total
// cfg       in         cfg_valid / cfg_ready          frames_in_use
//
// With n frames in use, one item occupies the block through lookup, which scans the
// frames up to and including a match (all n on a miss), aging of all n frames and
// hand-over of the result; no new page is taken until it goes to the output register.
// The one read port of the frame table is visited once per cycle by the shared
// compare unit during lookup and again during aging.
// Reset clears all frame valid bits and both totals; frames_in_use resets to 16.
// A result waiting in the output register does not block the next item until the
// sequencer needs to hand over a second result.
module aging_page_replacement
	import aprep_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [31:0]  s_axis_tdata,   // [31:0] page_number
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [103:0]      m_axis_tdata,   // [0] hit, [4:1] frame, [5] evicted,
	                                          // [37:6] evicted_page, [69:38] hit_total,
	                                          // [101:70] miss_total, [103:102] zero
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [4:0]   cfg_data        // [4:0] frames_in_use
);

	logic [CFG_W-1:0] frames_cfg_q;
	logic [IDX_W-1:0] rd_idx;
	frame_rd_t        rd;
	frame_wr_t        wr;
	logic             res_valid, res_free;
	result_t          res;
	logic             out_valid_q;
	result_t          out_q;

	assign cfg_ready = 1'b1;

	// Hold the frame count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frames_cfg_q <= CFG_RESET;
		else if (cfg_valid)
			frames_cfg_q <= cfg_data;
	end

	aprep_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.frames_cfg (frames_cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_page    (s_axis_tdata),
		.rd_idx     (rd_idx),
		.rd         (rd),
		.wr         (wr),
		.res_valid  (res_valid),
		.res_free   (res_free),
		.res        (res)
	);

	aprep_frames u_frames (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd     (rd),
		.wr     (wr)
	);

	// Output register: load when empty or being drained
	assign res_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_free)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.miss_total, out_q.hit_total, out_q.evicted_page,
		out_q.evicted, out_q.frame, out_q.hit};

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
module tb_top;
	import aprep_pkg::*;

	localparam int SETTLE_CYCLES = 2 * FRAMES + 8;

	// Expected outcome of one page reference
	typedef struct {
		logic        hit;
		logic [3:0]  frame;
		logic        evicted;
		logic [31:0] evicted_page;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} access_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata;   // [31:0] page_number
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [103:0]      m_axis_tdata;   // [0] hit, [4:1] frame, [5] evicted,
	                                   // [37:6] evicted_page, [69:38] hit_total,
	                                   // [101:70] miss_total
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data;       // [4:0] frames_in_use

	// Shadow copy of the frame table and counters
	logic              fr_valid [FRAMES];
	logic [31:0]       fr_page  [FRAMES];
	logic [AGE_W-1:0]  fr_age   [FRAMES];
	logic              fr_ref   [FRAMES];
	logic [31:0]       hit_cnt;
	logic [31:0]       miss_cnt;
	logic [CFG_W-1:0]  frames_reg;

	access_t           awaited_results[$];
	int                mismatches = 0;
	int                burst_left = 0;
	int                rx_hold_req = 0;
	int                rx_hold_left = 0;
	int                rx_run_left = 0;
	logic [31:0]       page_pool [48];
	int                pool_size;

	always #10 clk = ~clk;

	aging_page_replacement dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	function automatic int frames_active();
		int n;
		n = int'(frames_reg);
		if (n == 0)
			n = 1;
		if (n > FRAMES)
			n = FRAMES;
		return n;
	endfunction

	// Apply one page reference to the shadow table and return its outcome
	function automatic access_t predict_access(input logic [31:0] page);
		access_t     r;
		int          n;
		int          slot;
		bit          found;
		logic [7:0]  best;
		n = frames_active();
		slot = 0;
		found = 1'b0;
		r.hit = 1'b0;
		r.evicted = 1'b0;
		r.evicted_page = '0;
		// look up among valid frames
		for (int i = 0; i < n; i++) begin
			if (!found && fr_valid[i] && fr_page[i] == page) begin
				slot = i;
				found = 1'b1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			if (hit_cnt != 32'hFFFF_FFFF)
				hit_cnt++;
		end else begin
			if (miss_cnt != 32'hFFFF_FFFF)
				miss_cnt++;
			// take the lowest empty frame
			for (int i = 0; i < n; i++) begin
				if (!found && !fr_valid[i]) begin
					slot = i;
					found = 1'b1;
				end
			end
			// otherwise evict the oldest, lowest index on a tie
			if (!found) begin
				best = fr_age[0];
				slot = 0;
				for (int i = 1; i < n; i++) begin
					if (fr_age[i] < best) begin
						best = fr_age[i];
						slot = i;
					end
				end
				r.evicted = 1'b1;
				r.evicted_page = fr_page[slot];
			end
			fr_valid[slot] = 1'b1;
			fr_page[slot] = page;
			fr_age[slot] = '0;
		end
		fr_ref[slot] = 1'b1;
		// age every valid frame in use
		for (int i = 0; i < n; i++) begin
			if (fr_valid[i]) begin
				fr_age[i] = {fr_ref[i], fr_age[i][7:1]};
				fr_ref[i] = 1'b0;
			end
		end
		r.frame = slot[3:0];
		r.hit_total = hit_cnt;
		r.miss_total = miss_cnt;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		access_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time,
					m_axis_tdata);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("hit", want.hit, m_axis_tdata[0]);
				check_field("frame", want.frame, m_axis_tdata[4:1]);
				check_field("evicted", want.evicted, m_axis_tdata[5]);
				check_field("evicted_page", want.evicted_page, m_axis_tdata[37:6]);
				check_field("hit_total", want.hit_total, m_axis_tdata[69:38]);
				check_field("miss_total", want.miss_total, m_axis_tdata[101:70]);
			end
		end
	end

	// Receiver: random stalls, long ready stretches, and requested hold-offs
	always @(negedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_run_left > 0) begin
			rx_run_left--;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					m_axis_tready <= 1'b0;
					rx_run_left = $urandom_range(0, 12);
				end
				1: begin
					m_axis_tready <= 1'b1;
					rx_run_left = $urandom_range(20, 80);
				end
				default: begin
					m_axis_tready <= 1'($urandom_range(0, 1));
					rx_run_left = $urandom_range(0, 4);
				end
			endcase
		end
	end

	// Offer one page, record its outcome on acceptance, then maybe pause
	task automatic send_page(input logic [31:0] page);
		int gap;
		s_axis_tdata <= page;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		awaited_results.push_back(predict_access(page));
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(0, 40);
		end
	endtask

	// Hold the input and let every outstanding result drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] value);
		wait_idle();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		frames_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Extreme page numbers, first loads and first hits at the reset frame count
	task automatic test_fill_and_hit();
		send_page(32'h0000_0000);
		send_page(32'hFFFF_FFFF);
		send_page(32'h0000_0000);
		send_page(32'hAAAA_AAAA);
		send_page(32'h5555_5555);
	endtask

	// One frame, zero clamped to one, and hidden frames coming back into view
	task automatic test_frame_limits();
		write_frames(CFG_W'(1));
		send_page(32'h0000_0005);
		send_page(32'h0000_0005);
		send_page(32'hFFFF_FFFF);
		write_frames(CFG_W'(0));
		send_page(32'h0000_0000);
		write_frames(CFG_W'(16));
		send_page(32'hFFFF_FFFF);
		send_page(32'hAAAA_AAAA);
	endtask

	// Count above the table size: fill every frame, then force an eviction
	task automatic test_eviction();
		write_frames(CFG_W'(31));
		for (int i = 0; i < 12; i++)
			send_page(32'h0000_0100 + i);
		send_page(32'h1234_5678);
	endtask

	// Build a small working set sized around the active frame count
	task automatic fill_pool();
		int n;
		n = frames_active();
		pool_size = $urandom_range((n < 4) ? 2 : n / 2, n + n / 2 + 2);
		for (int i = 0; i < pool_size; i++) begin
			if (i > 0 && $urandom_range(0, 3) == 0)
				page_pool[i] = page_pool[$urandom_range(0, i - 1)]
					^ (32'h1 << $urandom_range(0, 31));
			else
				page_pool[i] = $urandom;
		end
	endtask

	function automatic logic [31:0] pick_page();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			default: return page_pool[$urandom_range(0, $urandom_range(0, pool_size - 1))];
		endcase
	endfunction

	// Hold off the receiver while pages keep coming, so the input stalls
	task automatic test_backpressure();
		fill_pool();
		rx_hold_req = 300;
		repeat (24) send_page(pick_page());
		wait_idle();
	endtask

	// Random references over a sequence of frame counts
	task automatic test_random();
		logic [CFG_W-1:0] counts [10];
		counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd15, 5'd17, 5'd0, 5'd0, 5'd0};
		for (int k = 7; k < 10; k++)
			counts[k] = CFG_W'($urandom_range(0, 31));
		foreach (counts[p]) begin
			write_frames(counts[p]);
			fill_pool();
			repeat (160) send_page(pick_page());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		frames_reg = CFG_RESET;
		hit_cnt = '0;
		miss_cnt = '0;
		for (int i = 0; i < FRAMES; i++) begin
			fr_valid[i] = 1'b0;
			fr_page[i] = '0;
			fr_age[i] = '0;
			fr_ref[i] = 1'b0;
		end
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_fill_and_hit();
		test_frame_limits();
		test_eviction();
		test_backpressure();
		test_random();

		wait_idle();
		if (mismatches == 0)
			$display("aging_page_replacement regression: pass");
		else
			$display("aging_page_replacement regression: fail");
		$finish;
	end

	// Stop a hung run
	initial begin
		#20_000_000;
		$display("aging_page_replacement regression: fail");
		$finish;
	end

endmodule
